### hw/rtl/usq_pkg.sv
// ---------------------------------------------------------------------------
// usq_pkg: shared types and constants of the upshift sequencer
// Phase and spark codes, configuration and result records, reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package usq_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int GEAR_BITS_DEF  = 4;

  localparam int TIME_W  = 32;
  localparam int LIMIT_W = 16;
  localparam int TOTAL_W = 16;
  localparam int CFG_AW  = 3;

  // Shift phases
  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_PRELOAD   = 3'd1,
    PH_EXIT      = 3'd2,
    PH_SPARK_RET = 3'd3,
    PH_ENTER     = 3'd4,
    PH_EXTRA     = 3'd5,
    PH_FINISH    = 3'd6
  } phase_t;

  // Spark-cut command codes
  typedef enum logic [1:0] {
    SPK_NONE  = 2'd0,
    SPK_GUARD = 2'd1,
    SPK_FORCE = 2'd2,
    SPK_RPM   = 2'd3
  } spark_t;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_TIME_ONLY     = 3'd0,
    REG_PRELOAD       = 3'd1,
    REG_EXIT_TIMEOUT  = 3'd2,
    REG_EXIT_TIME     = 3'd3,
    REG_SPARK_RETURN  = 3'd4,
    REG_ENTER_TIMEOUT = 3'd5,
    REG_ENTER_TIME    = 3'd6,
    REG_EXTRA_PUSH    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic               time_only_mode;
    logic [LIMIT_W-1:0] preload_ms;
    logic [LIMIT_W-1:0] exit_timeout_ms;
    logic [LIMIT_W-1:0] exit_time_ms;
    logic [LIMIT_W-1:0] spark_return_ms;
    logic [LIMIT_W-1:0] enter_timeout_ms;
    logic [LIMIT_W-1:0] enter_time_ms;
    logic [LIMIT_W-1:0] extra_push_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    time_only_mode:   1'b0,
    preload_ms:       16'd10,
    exit_timeout_ms:  16'd50,
    exit_time_ms:     16'd20,
    spark_return_ms:  16'd20,
    enter_timeout_ms: 16'd50,
    enter_time_ms:    16'd20,
    extra_push_ms:    16'd10
  };

  // One result word, last field in the lowest bits when packed
  typedef struct packed {
    logic [TOTAL_W-1:0] good_shifts;
    logic [TOTAL_W-1:0] total_shifts;
    logic               busy_res;
    logic               shift_success;
    logic               shift_done;
    logic               timeout_error;
    spark_t             spark_cmd;
    logic               sol_drive;
  } res_t;

  localparam int RES_W     = $bits(res_t);
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

### hw/rtl/upshift_sequencer_top.sv
// ---------------------------------------------------------------------------
// upshift_sequencer_top: gearbox upshift sequencer
// Feed one word per control tick on the in_ stream; each tick yields one
// result word on the out_ stream with solenoid drive, spark-cut code,
// timeout, done/success flags, busy and the shift counters.
// Timing registers are written through cfg_we/cfg_addr/cfg_wdata; the user
// must write them only while the block is idle (the block does not enforce
// it); cfg_addr is the register index. A word accepted on in_ is held in
// the input register; its result is registered in the result register.
// Throughput: one word per cycle while out_tready is high; the phase logic
// is a subtract, compares and a phase mux between the input and result registers.
// Reset (rst_n low, synchronous): phase idle, counters zero, timing
// registers at their defaults, both streams empty.
// When out_tready is low the result word holds and one more tick word is
// taken into the input register; after that in_tready drops.
// ---------------------------------------------------------------------------
`default_nettype none

module upshift_sequencer_top
  import usq_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int GEAR_BITS  = GEAR_BITS_DEF,
  localparam int IN_FIELDS_W = TIME_W + GEAR_BITS + 1,
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // now_ms [31:0], gear_state [32+:GEAR_BITS], start_shift, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // sol_drive, spark_cmd[2], timeout_error, shift_done, shift_success,
  // busy_res, total_shifts[16], good_shifts[16], zero pad
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_AW-1:0]      cfg_addr,
  input  wire logic [LIMIT_W-1:0]     cfg_wdata
);

  cfg_t                 cfg;
  logic                 take;
  logic                 s1_valid;
  logic [TIME_W-1:0]    s1_now;
  logic [GEAR_BITS-1:0] s1_gear;
  logic                 s1_start;
  res_t                 res_comb;
  res_t                 res_q;

  usq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  usq_in_reg #(
    .GEAR_BITS (GEAR_BITS)
  ) u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .now_ms_i (in_tdata[TIME_W-1:0]),
    .gear_i   (in_tdata[TIME_W +: GEAR_BITS]),
    .start_i  (in_tdata[TIME_W + GEAR_BITS]),
    .take     (take),
    .valid_o  (s1_valid),
    .now_ms_o (s1_now),
    .gear_o   (s1_gear),
    .start_o  (s1_start)
  );

  usq_core #(
    .COUNT_BITS (COUNT_BITS),
    .GEAR_BITS  (GEAR_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_i  (cfg),
    .take   (take),
    .now_ms (s1_now),
    .gear   (s1_gear),
    .start  (s1_start),
    .res_o  (res_comb)
  );

  usq_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (s1_valid),
    .res_i     (res_comb),
    .take      (take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_o     (res_q)
  );

  assign out_tdata = OUT_TDATA_W'(res_q);

endmodule

`default_nettype wire

### hw/rtl/usq_cfg.sv
// ---------------------------------------------------------------------------
// usq_cfg: configuration register file
// Holds the eight shift timing and mode registers, written by index.
// ---------------------------------------------------------------------------
`default_nettype none

module usq_cfg
  import usq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [CFG_AW-1:0]  cfg_addr,
  input  wire logic [LIMIT_W-1:0] cfg_wdata,
  output cfg_t                    cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_TIME_ONLY:     cfg_nxt.time_only_mode   = cfg_wdata[0];
        REG_PRELOAD:       cfg_nxt.preload_ms       = cfg_wdata;
        REG_EXIT_TIMEOUT:  cfg_nxt.exit_timeout_ms  = cfg_wdata;
        REG_EXIT_TIME:     cfg_nxt.exit_time_ms     = cfg_wdata;
        REG_SPARK_RETURN:  cfg_nxt.spark_return_ms  = cfg_wdata;
        REG_ENTER_TIMEOUT: cfg_nxt.enter_timeout_ms = cfg_wdata;
        REG_ENTER_TIME:    cfg_nxt.enter_time_ms    = cfg_wdata;
        REG_EXTRA_PUSH:    cfg_nxt.extra_push_ms    = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

### hw/rtl/usq_in_reg.sv
// ---------------------------------------------------------------------------
// usq_in_reg: input word register
// Captures one tick word and holds it until the sequencer consumes it.
// ---------------------------------------------------------------------------
`default_nettype none

module usq_in_reg
  import usq_pkg::*;
#(
  parameter int GEAR_BITS = GEAR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [TIME_W-1:0]    now_ms_i,
  input  wire logic [GEAR_BITS-1:0] gear_i,
  input  wire logic                 start_i,
  input  wire logic                 take,
  output logic                      valid_o,
  output logic [TIME_W-1:0]         now_ms_o,
  output logic [GEAR_BITS-1:0]      gear_o,
  output logic                      start_o
);

  logic                 valid_r;
  logic [TIME_W-1:0]    now_ms_r;
  logic [GEAR_BITS-1:0] gear_r;
  logic                 start_r;

  // Accept a new word when empty or whenever the held one leaves this cycle
  assign in_ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      now_ms_r <= now_ms_i;
      gear_r   <= gear_i;
      start_r  <= start_i;
    end
  end

  assign valid_o  = valid_r;
  assign now_ms_o = now_ms_r;
  assign gear_o   = gear_r;
  assign start_o  = start_r;

endmodule

`default_nettype wire

### hw/rtl/usq_core.sv
// ---------------------------------------------------------------------------
// usq_core: shift phase sequencer
// Keeps phase, start gear, phase start time and shift counters, and forms
// the result of one tick from the held input word.
// ---------------------------------------------------------------------------
`default_nettype none

module usq_core
  import usq_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int GEAR_BITS  = GEAR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cfg_t                 cfg_i,
  input  wire logic                 take,
  input  wire logic [TIME_W-1:0]    now_ms,
  input  wire logic [GEAR_BITS-1:0] gear,
  input  wire logic                 start,
  output res_t                      res_o
);

  phase_t                phase_r, phase_nxt;
  logic [GEAR_BITS-1:0]  start_gear_r, start_gear_nxt;
  logic [TIME_W-1:0]     phase_start_r, phase_start_nxt;
  logic [COUNT_BITS-1:0] shift_cnt_r, shift_cnt_nxt;
  logic [COUNT_BITS-1:0] good_cnt_r, good_cnt_nxt;

  logic [TIME_W-1:0]     elapsed;
  logic [LIMIT_W-1:0]    limit;
  logic                  over;
  logic [GEAR_BITS:0]    target;
  logic                  gear_up;
  logic                  gear_at;
  logic                  gear_ge;
  logic                  timed;

  assign timed = cfg_i.time_only_mode;

  // Pick the time limit of the current phase
  always_comb begin
    case (phase_r)
      PH_PRELOAD:   limit = cfg_i.preload_ms;
      PH_EXIT:      limit = timed ? cfg_i.exit_time_ms : cfg_i.exit_timeout_ms;
      PH_SPARK_RET: limit = cfg_i.spark_return_ms;
      PH_ENTER:     limit = timed ? cfg_i.enter_time_ms : cfg_i.enter_timeout_ms;
      PH_EXTRA:     limit = cfg_i.extra_push_ms;
      default:      limit = '0;
    endcase
  end

  // Wrapping elapsed time against the limit
  assign elapsed = now_ms - phase_start_r;
  assign over    = elapsed > TIME_W'(limit);

  // Gear compares, target kept one bit wider so it never wraps
  assign target  = {1'b0, start_gear_r} + (GEAR_BITS+1)'(2);
  assign gear_up = gear > start_gear_r;
  assign gear_at = {1'b0, gear} == target;
  assign gear_ge = {1'b0, gear} >= target;

  // Phase transitions and tick outputs
  always_comb begin
    phase_nxt       = phase_r;
    start_gear_nxt  = start_gear_r;
    phase_start_nxt = phase_start_r;
    shift_cnt_nxt   = shift_cnt_r;
    good_cnt_nxt    = good_cnt_r;
    res_o           = '0;
    res_o.sol_drive = 1'b1;
    res_o.spark_cmd = SPK_NONE;

    case (phase_r)
      PH_PRELOAD: begin
        if (over) begin
          phase_start_nxt = now_ms;
          res_o.spark_cmd = SPK_GUARD;
          phase_nxt       = PH_EXIT;
        end
      end
      PH_EXIT: begin
        res_o.spark_cmd = SPK_GUARD;
        if (!timed) begin
          if (gear_up) begin
            phase_start_nxt = now_ms;
            phase_nxt       = PH_ENTER;
          end else if (over) begin
            res_o.timeout_error = 1'b1;
            res_o.spark_cmd     = SPK_NONE;
            phase_start_nxt     = now_ms;
            phase_nxt           = PH_SPARK_RET;
          end
        end else if (over) begin
          phase_start_nxt = now_ms;
          phase_nxt       = PH_ENTER;
        end
      end
      PH_SPARK_RET: begin
        res_o.spark_cmd = SPK_GUARD;
        if (gear_up || over) begin
          phase_start_nxt = now_ms;
          phase_nxt       = PH_ENTER;
        end
      end
      PH_ENTER: begin
        if (!timed) begin
          res_o.spark_cmd = SPK_RPM;
          if (gear_at) begin
            phase_start_nxt = now_ms;
            phase_nxt       = PH_EXTRA;
          end else if (over) begin
            res_o.timeout_error = 1'b1;
            phase_start_nxt     = now_ms;
            phase_nxt           = PH_EXTRA;
          end
        end else begin
          res_o.spark_cmd = SPK_FORCE;
          if (over) begin
            phase_start_nxt = now_ms;
            phase_nxt       = PH_EXTRA;
          end
        end
      end
      PH_EXTRA: begin
        if (over) begin
          phase_nxt = PH_FINISH;
        end
      end
      PH_FINISH: begin
        res_o.sol_drive  = 1'b0;
        res_o.shift_done = 1'b1;
        shift_cnt_nxt    = shift_cnt_r + COUNT_BITS'(1);
        if (gear_ge) begin
          res_o.shift_success = 1'b1;
          good_cnt_nxt        = good_cnt_r + COUNT_BITS'(1);
        end
        phase_nxt = PH_IDLE;
      end
      default: begin
        // Idle, and any unused code behaves as idle
        phase_nxt = PH_IDLE;
        if (start) begin
          start_gear_nxt  = gear;
          phase_start_nxt = now_ms;
          phase_nxt       = PH_PRELOAD;
        end else begin
          res_o.sol_drive = 1'b0;
        end
      end
    endcase

    res_o.busy_res     = phase_nxt != PH_IDLE;
    res_o.total_shifts = TOTAL_W'(shift_cnt_nxt);
    res_o.good_shifts  = TOTAL_W'(good_cnt_nxt);
  end

  // Commit state only when the tick result moves to the output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      start_gear_r  <= '0;
      phase_start_r <= '0;
      shift_cnt_r   <= '0;
      good_cnt_r    <= '0;
    end else if (take) begin
      phase_r       <= phase_nxt;
      start_gear_r  <= start_gear_nxt;
      phase_start_r <= phase_start_nxt;
      shift_cnt_r   <= shift_cnt_nxt;
      good_cnt_r    <= good_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/usq_out_reg.sv
// ---------------------------------------------------------------------------
// usq_out_reg: result word register
// Holds one result word for the receiver and pulls the next one in when
// the register is empty or being drained.
// ---------------------------------------------------------------------------
`default_nettype none

module usq_out_reg
  import usq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic src_valid,
  input  wire res_t res_i,
  output logic      take,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      res_o
);

  logic valid_r;
  res_t res_r;

  // Load when empty or when the held word is taken this cycle
  assign take = src_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_i;
    end
  end

  assign out_valid = valid_r;
  assign res_o     = res_r;

endmodule

`default_nettype wire

### dv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: upshift sequencer stream test
// Sends tick words (timestamp, gear, start pulse) and predicts each result
// word with an independent model of the shift phases, then checks each
// result field by field. Covers directed shifts, several timing settings
// including the extremes, randomized shift traffic and output backpressure.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import usq_pkg::*;

  localparam int IN_W        = ((TIME_W + GEAR_BITS_DEF + 1 + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_W-1:0]        in_tdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  reg_idx_t               cfg_addr = REG_TIME_ONLY;
  logic [LIMIT_W-1:0]     cfg_wdata = '0;

  upshift_sequencer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock
  initial begin
    forever #6 clk = ~clk;
  end

  // Shift predictor state and timing copy
  phase_t      seq_phase = PH_IDLE;
  logic [3:0]  seq_start_gear = '0;
  logic [31:0] seq_phase_t0 = '0;
  logic [15:0] seq_shifts = '0;
  logic [15:0] seq_good = '0;
  cfg_t        seq_cfg = CFG_RESET;

  res_t        tick_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Stimulus state
  logic [31:0] tb_ms = '0;
  logic [3:0]  tb_gear = '0;
  int unsigned burst_left = 0;

  // Receiver state
  int unsigned rx_hold_left = 0;
  int unsigned rx_hold_reqs = 0;
  int unsigned rx_hold_served = 0;
  int unsigned rx_style = 0;
  int unsigned rx_tick = 0;

  res_t got_res;
  res_t want_res;

  function automatic logic elapsed_over(input logic [31:0] now, input logic [15:0] lim);
    logic [31:0] span;
    span = now - seq_phase_t0;
    return span > {16'd0, lim};
  endfunction

  // Advance the shift model by one tick and form the result word
  task automatic predict_tick(input logic [31:0] now, input logic [3:0] gear,
                              input logic start, output res_t r);
    r = '0;
    r.sol_drive = 1'b1;
    r.spark_cmd = SPK_NONE;
    case (seq_phase)
      PH_PRELOAD: begin
        if (elapsed_over(now, seq_cfg.preload_ms)) begin
          seq_phase_t0 = now;
          r.spark_cmd = SPK_GUARD;
          seq_phase = PH_EXIT;
        end
      end
      PH_EXIT: begin
        r.spark_cmd = SPK_GUARD;
        if (!seq_cfg.time_only_mode) begin
          if (gear > seq_start_gear) begin
            seq_phase_t0 = now;
            seq_phase = PH_ENTER;
          end else if (elapsed_over(now, seq_cfg.exit_timeout_ms)) begin
            r.timeout_error = 1'b1;
            r.spark_cmd = SPK_NONE;
            seq_phase_t0 = now;
            seq_phase = PH_SPARK_RET;
          end
        end else if (elapsed_over(now, seq_cfg.exit_time_ms)) begin
          seq_phase_t0 = now;
          seq_phase = PH_ENTER;
        end
      end
      PH_SPARK_RET: begin
        r.spark_cmd = SPK_GUARD;
        if (gear > seq_start_gear || elapsed_over(now, seq_cfg.spark_return_ms)) begin
          seq_phase_t0 = now;
          seq_phase = PH_ENTER;
        end
      end
      PH_ENTER: begin
        if (!seq_cfg.time_only_mode) begin
          r.spark_cmd = SPK_RPM;
          // target compared unwrapped: start gears 14 and 15 never match
          if ({1'b0, gear} == {1'b0, seq_start_gear} + 5'd2) begin
            seq_phase_t0 = now;
            seq_phase = PH_EXTRA;
          end else if (elapsed_over(now, seq_cfg.enter_timeout_ms)) begin
            r.timeout_error = 1'b1;
            seq_phase_t0 = now;
            seq_phase = PH_EXTRA;
          end
        end else begin
          r.spark_cmd = SPK_FORCE;
          if (elapsed_over(now, seq_cfg.enter_time_ms)) begin
            seq_phase_t0 = now;
            seq_phase = PH_EXTRA;
          end
        end
      end
      PH_EXTRA: begin
        if (elapsed_over(now, seq_cfg.extra_push_ms)) seq_phase = PH_FINISH;
      end
      PH_FINISH: begin
        r.sol_drive = 1'b0;
        r.shift_done = 1'b1;
        seq_shifts = seq_shifts + 16'd1;
        if ({1'b0, gear} >= {1'b0, seq_start_gear} + 5'd2) begin
          r.shift_success = 1'b1;
          seq_good = seq_good + 16'd1;
        end
        seq_phase = PH_IDLE;
      end
      default: begin
        seq_phase = PH_IDLE;
        if (start) begin
          seq_start_gear = gear;
          seq_phase_t0 = now;
          seq_phase = PH_PRELOAD;
        end else begin
          r.sol_drive = 1'b0;
        end
      end
    endcase
    r.busy_res = (seq_phase != PH_IDLE);
    r.total_shifts = seq_shifts;
    r.good_shifts = seq_good;
  endtask

  // Send one tick word in bursts; predict its result once accepted
  task automatic send_tick(input logic [31:0] now, input logic [3:0] gear, input logic start);
    res_t r;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 40);
    end
    in_tdata <= {{(IN_W - TIME_W - 5){1'b0}}, start, gear, now};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predict_tick(now, gear, start, r);
    tick_results.push_back(r);
    burst_left--;
    // end of burst: drop valid for a random gap
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Hold the input until every pending result has come, then let the pipe settle
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (tick_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TIME_ONLY:     seq_cfg.time_only_mode = val[0];
      REG_PRELOAD:       seq_cfg.preload_ms = val;
      REG_EXIT_TIMEOUT:  seq_cfg.exit_timeout_ms = val;
      REG_EXIT_TIME:     seq_cfg.exit_time_ms = val;
      REG_SPARK_RETURN:  seq_cfg.spark_return_ms = val;
      REG_ENTER_TIMEOUT: seq_cfg.enter_timeout_ms = val;
      REG_ENTER_TIME:    seq_cfg.enter_time_ms = val;
      REG_EXTRA_PUSH:    seq_cfg.extra_push_ms = val;
      default: ;
    endcase
  endtask

  task automatic apply_timing(input cfg_t c);
    settle();
    write_reg(REG_TIME_ONLY, {15'd0, c.time_only_mode});
    write_reg(REG_PRELOAD, c.preload_ms);
    write_reg(REG_EXIT_TIMEOUT, c.exit_timeout_ms);
    write_reg(REG_EXIT_TIME, c.exit_time_ms);
    write_reg(REG_SPARK_RETURN, c.spark_return_ms);
    write_reg(REG_ENTER_TIMEOUT, c.enter_timeout_ms);
    write_reg(REG_ENTER_TIME, c.enter_time_ms);
    write_reg(REG_EXTRA_PUSH, c.extra_push_ms);
  endtask

  // Shift-shaped traffic: starts mostly while idle, gear steps toward the target
  task automatic run_shift_traffic(input int n, input int unsigned step_max);
    for (int i = 0; i < n; i++) begin
      int unsigned pick;
      logic [3:0]  g;
      logic        st;
      if ($urandom_range(0, 39) == 0) tb_ms = $urandom();
      else tb_ms = tb_ms + $urandom_range(0, step_max);
      pick = $urandom_range(0, 15);
      g = tb_gear;
      if (pick == 0) begin
        g = 4'($urandom_range(0, 15));
      end else begin
        case (seq_phase)
          PH_IDLE: begin
            if (pick < 4) g = 4'($urandom_range(0, 15));
          end
          PH_EXIT, PH_SPARK_RET: begin
            if (pick < 5) g = seq_start_gear + 4'd1;
          end
          PH_ENTER: begin
            if (pick < 5) g = seq_start_gear + 4'd2;
            else if (pick < 7) g = seq_start_gear + 4'd1;
          end
          PH_FINISH: begin
            if (pick < 3) g = seq_start_gear + 4'd3;
          end
          default: ;
        endcase
      end
      tb_gear = g;
      st = (seq_phase == PH_IDLE) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 9) == 0);
      send_tick(tb_ms, g, st);
    end
  endtask

  function automatic cfg_t random_timing();
    cfg_t c;
    c.time_only_mode = 1'($urandom_range(0, 1));
    c.preload_ms = 16'($urandom_range(0, 40));
    c.exit_timeout_ms = 16'($urandom_range(0, 40));
    c.exit_time_ms = 16'($urandom_range(0, 40));
    c.spark_return_ms = 16'($urandom_range(0, 40));
    c.enter_timeout_ms = 16'($urandom_range(0, 40));
    c.enter_time_ms = 16'($urandom_range(0, 40));
    c.extra_push_ms = 16'($urandom_range(0, 40));
    return c;
  endfunction

  // Directed shifts at reset timing: success, timeouts, wrap, mode change
  task automatic test_directed_shifts();
    // sensor shift that succeeds; start while busy ignored
    send_tick(32'd100, 4'd2, 1'b0);
    send_tick(32'd101, 4'd2, 1'b1);
    send_tick(32'd105, 4'd2, 1'b1);
    send_tick(32'd112, 4'd2, 1'b0);
    send_tick(32'd113, 4'd3, 1'b0);
    send_tick(32'd114, 4'd4, 1'b0);
    send_tick(32'd125, 4'd4, 1'b0);
    send_tick(32'd126, 4'd4, 1'b0);
    // gear 14 across the time wrap: exit timeout, unreachable entry target
    send_tick(32'hFFFF_FFF0, 4'd14, 1'b1);
    send_tick(32'hFFFF_FFFB, 4'd14, 1'b0);
    send_tick(32'h0000_002E, 4'd14, 1'b0);
    send_tick(32'h0000_002F, 4'd15, 1'b0);
    send_tick(32'h0000_0063, 4'd15, 1'b0);
    send_tick(32'h0000_006E, 4'd15, 1'b0);
    send_tick(32'h0000_006F, 4'd15, 1'b1);
    // gear 0, spark return ends by time
    send_tick(32'h0000_0070, 4'd0, 1'b1);
    send_tick(32'h0000_007B, 4'd0, 1'b0);
    send_tick(32'h0000_00AF, 4'd0, 1'b0);
    send_tick(32'h0000_00C4, 4'd0, 1'b0);
    // switch to timed mode in the middle of the enter phase
    settle();
    write_reg(REG_TIME_ONLY, 16'd1);
    send_tick(32'h0000_00C5, 4'd2, 1'b0);
    send_tick(32'h0000_00D9, 4'd2, 1'b0);
    send_tick(32'h0000_00E4, 4'd2, 1'b0);
    send_tick(32'h0000_00E5, 4'd15, 1'b0);
    send_tick(32'hFFFF_FFFF, 4'd15, 1'b1);
    send_tick(32'hFFFF_FFFF, 4'd15, 1'b0);
    tb_ms = 32'hFFFF_FFFF;
    tb_gear = 4'd15;
    settle();
    write_reg(REG_TIME_ONLY, 16'd0);
  endtask

  task automatic test_default_timing();
    run_shift_traffic(460, 12);
  endtask

  task automatic test_zero_limits();
    cfg_t c;
    c = '0;
    apply_timing(c);
    run_shift_traffic(250, 2);
    c.time_only_mode = 1'b1;
    apply_timing(c);
    run_shift_traffic(200, 2);
  endtask

  task automatic test_max_limits();
    cfg_t c;
    c = '1;
    c.time_only_mode = 1'b0;
    apply_timing(c);
    run_shift_traffic(250, 9000);
    c.time_only_mode = 1'b1;
    apply_timing(c);
    run_shift_traffic(200, 9000);
  endtask

  task automatic test_random_timing();
    repeat (3) begin
      apply_timing(random_timing());
      run_shift_traffic(120, 15);
    end
  endtask

  // Hold off the receiver for a long stretch while words keep coming
  task automatic test_output_backpressure();
    apply_timing(CFG_RESET);
    rx_hold_reqs <= rx_hold_reqs + 1;
    run_shift_traffic(100, 12);
  endtask

  // Receiver: long hold on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_hold_left != 0) begin
      out_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_reqs != rx_hold_served) begin
      rx_hold_served <= rx_hold_served + 1;
      rx_hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (rx_tick % 97 == 0) rx_style <= $urandom_range(0, 3);
      case (rx_style)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ((rx_tick % 7) < 4);
        default: out_tready <= ($urandom_range(0, 1) != 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got_res = res_t'(out_tdata[RES_W-1:0]);
      if (tick_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, actual %0h", $time, out_tdata);
      end else begin
        want_res = tick_results.pop_front();
        check_field("sol_drive", 16'(want_res.sol_drive), 16'(got_res.sol_drive));
        check_field("spark_cmd", 16'(want_res.spark_cmd), 16'(got_res.spark_cmd));
        check_field("timeout_error", 16'(want_res.timeout_error),
                    16'(got_res.timeout_error));
        check_field("shift_done", 16'(want_res.shift_done), 16'(got_res.shift_done));
        check_field("shift_success", 16'(want_res.shift_success),
                    16'(got_res.shift_success));
        check_field("busy_res", 16'(want_res.busy_res), 16'(got_res.busy_res));
        check_field("total_shifts", want_res.total_shifts, got_res.total_shifts);
        check_field("good_shifts", want_res.good_shifts, got_res.good_shifts);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_shifts();
    test_default_timing();
    test_zero_limits();
    test_max_limits();
    test_random_timing();
    test_output_backpressure();
    settle();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
